>>> src/cml_pkg.sv
// Shared types, constants and month tables for the calendar month layout block.
package cml_pkg;

   // Field widths of the request and response beats
   localparam int MonthWidth   = 4;
   localparam int YearWidth    = 14;
   localparam int DayWidth     = 5;
   localparam int RowWidth     = 3;
   localparam int ColWidth     = 3;
   localparam int ReqDataWidth = 24;
   localparam int RspDataWidth = 16;

   // Range limits of the request
   localparam int MonthMin = 1;
   localparam int MonthMax = 12;
   localparam int YearMin  = 1;
   localparam int YearMax  = 9999;

   // Calendar constants
   localparam int YearChangeover  = 1752;
   localparam int YearCenturyRule = 1800;
   localparam int CenturyBase     = 1701;
   localparam int QuadCenturyBase = 1601;
   localparam int EpochWeekday    = 4;
   localparam int GregorianShift  = 3;
   localparam int DaysInWeek      = 7;
   localparam int MonthFebruary   = 2;
   localparam int MonthSeptember  = 9;
   localparam int SkipLastBefore  = 2;
   localparam int SkipResume      = 14;
   localparam int ChangeoverLast  = 30;

   // Reciprocal multipliers: x/100 exact below 43699, x/7 low by at most one
   localparam int Recip100      = 5243;
   localparam int Recip100Shift = 19;
   localparam int Recip7        = 9362;
   localparam int Recip7Shift   = 16;

   typedef enum logic [1:0] {
      KIND_COMMON     = 2'd0,
      KIND_LEAP       = 2'd1,
      KIND_CHANGEOVER = 2'd2
   } year_kind_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic pass;
      logic div_en;
      logic sum_en;
      logic mul_en;
      logic fix_en;
      logic kind_en;
      logic month_step;
      logic emit_init;
      logic emit_advance;
   } cml_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic bad;
      logic month_done;
      logic beat_last;
   } cml_status_type;

   // Length of a month for a given year kind
   function automatic logic [DayWidth-1:0] month_len(input logic [MonthWidth-1:0] month,
                                                     input year_kind_type kind);
      logic [DayWidth-1:0] len;
      case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: begin
            len = 5'd31;
         end
         4'd4, 4'd6, 4'd11: begin
            len = 5'd30;
         end
         4'd9: begin
            len = (kind == KIND_CHANGEOVER) ? 5'd19 : 5'd30;
         end
         4'd2: begin
            len = (kind == KIND_COMMON) ? 5'd28 : 5'd29;
         end
         default: begin
            len = 5'd0;
         end
      endcase
      return len;
   endfunction

   // Month length modulo seven
   function automatic logic [ColWidth-1:0] len_mod7(input logic [DayWidth-1:0] len);
      logic [ColWidth-1:0] r;
      case (len)
         5'd28:   r = 3'd0;
         5'd29:   r = 3'd1;
         5'd30:   r = 3'd2;
         5'd31:   r = 3'd3;
         5'd19:   r = 3'd5;
         default: r = 3'd0;
      endcase
      return r;
   endfunction

endpackage

>>> src/calendar_month_layout.sv
// Top level of the calendar month layout block.
// One request beat carries a month and a year; the block answers with one response
// beat per printed day of that month, in order, each giving the day number and its
// week row and weekday column (Sunday is column 0) in a six-row grid, with tlast on
// the final day. The weekday of January 1 follows the Julian calendar up to 1752 and
// the Gregorian calendar after it; September 1752 skips days 3 to 13. A month outside
// 1..12 or a year outside 1..9999 gives a single beat with tuser set and zero data.
// Requests are handled one at a time: a valid request is accepted, range checked, sent
// twice through the shared divide and modulo datapath (divide, sum, multiply, fix) for
// this year and the next, given its year kind, walked month by month to its offset and
// answered with one day beat per cycle while rsp_tready is high; a bad request goes from
// the range check straight to its error beat. A new request is taken only after the
// last beat of the previous one.
module calendar_month_layout (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [cml_pkg::ReqDataWidth-1:0]   req_tdata,  // month[3:0], year[17:4]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [cml_pkg::RspDataWidth-1:0]   rsp_tdata,  // day_number[4:0], grid_row[7:5],
                                                          // grid_column[10:8]
   output logic                               rsp_tuser,  // bad_argument
   output logic                               rsp_tlast   // last
);
   import cml_pkg::*;

   cml_cmd_type    cmd;
   cml_status_type status;

   cml_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   cml_datapath u_datapath (
      .clock     (clock),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

`ifndef SYNTH
   // Error beat carries zero data and closes the request
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> (rsp_tdata == '0) && rsp_tlast)
      else $error("error beat with nonzero data or without tlast");

   // Day beats stay inside the grid
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> (rsp_tdata[4:0] != 5'd0) && (rsp_tdata[7:5] <= 3'd5) &&
                                   (rsp_tdata[10:8] <= 3'd6))
      else $error("day beat outside the month grid");

   // No request is taken while beats are pending
   assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("request ready while a response is pending");

   // A taken beat that is not last is followed by the next beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("response run ended without tlast");
`endif

endmodule

>>> src/cml_datapath.sv
// Datapath: weekday arithmetic, month offset accumulation and day cell generation.
module cml_datapath (
   input  logic                               clock,
   input  logic [cml_pkg::ReqDataWidth-1:0]   req_tdata,
   input  cml_pkg::cml_cmd_type               cmd,
   output cml_pkg::cml_status_type            status,
   output logic [cml_pkg::RspDataWidth-1:0]   rsp_tdata,  // day_number, grid_row, grid_column
   output logic                               rsp_tuser,  // bad_argument
   output logic                               rsp_tlast
);
   import cml_pkg::*;

   logic [MonthWidth-1:0] month_ff;
   logic [YearWidth-1:0]  year_ff;
   logic [15:0]           base_ff;
   logic [7:0]            q100_ff;
   logic [5:0]            q400_ff;
   logic                  gt1800_ff;
   logic                  gt1752_ff;
   logic [15:0]           d_ff;
   logic [13:0]           q7_ff;
   logic [ColWidth-1:0]   wd0_ff;
   logic [ColWidth-1:0]   wd1_ff;
   year_kind_type         kind_ff;
   logic [MonthWidth-1:0] mcnt_ff;
   logic [DayWidth-1:0]   day_ff;
   logic [RowWidth-1:0]   row_ff;
   logic [ColWidth-1:0]   col_ff;
   logic                  bad_ff;
   logic                  last_ff;

   logic [YearWidth-1:0]  yr_op;
   logic [YearWidth-1:0]  x100;
   logic [YearWidth-1:0]  x400;
   logic [26:0]           p100;
   logic [26:0]           p400;
   logic [15:0]           base_in;
   logic [15:0]           d_in;
   logic [29:0]           p7;
   logic [15:0]           rem;
   logic [ColWidth-1:0]   wd_in;
   logic [3:0]            diff;
   logic [3:0]            diff_mod;
   year_kind_type         kind_in;
   logic [3:0]            col_sum;
   logic [ColWidth-1:0]   col_step;
   logic                  skip;
   logic [DayWidth-1:0]   last_day;
   logic [DayWidth-1:0]   day_next;
   logic [DayWidth-1:0]   day_in;
   logic [RowWidth-1:0]   row_in;
   logic [ColWidth-1:0]   col_in;
   logic                  last_in;
   logic                  bad_in;

   // Pick this year or the next one for the current weekday pass
   assign yr_op = cmd.pass ? (year_ff + 14'd1) : year_ff;

   // Century corrections by reciprocal multiply
   always_comb begin
      x100    = yr_op - 14'(CenturyBase);
      x400    = yr_op - 14'(QuadCenturyBase);
      p100    = 27'(x100) * 27'(Recip100);
      p400    = 27'(x400) * 27'(Recip100);
      base_in = 16'(EpochWeekday) + 16'(yr_op) + 16'((yr_op + 14'd3) >> 2);
   end

   // Sum the Julian base and the Gregorian corrections
   always_comb begin
      d_in = base_ff;
      if (gt1800_ff) begin
         d_in = d_in - 16'(q100_ff) + 16'(q400_ff);
      end
      if (gt1752_ff) begin
         d_in = d_in + 16'(GregorianShift);
      end
   end

   // Reduce modulo seven: quotient estimate, then one correction
   always_comb begin
      p7  = 30'(d_ff) * 30'(Recip7);
      rem = d_ff - {q7_ff[12:0], 3'b000} + 16'(q7_ff);
      if (rem >= 16'(DaysInWeek)) begin
         wd_in = 3'(rem - 16'(DaysInWeek));
      end else begin
         wd_in = rem[ColWidth-1:0];
      end
   end

   // Year kind from the weekday step between this year and the next
   always_comb begin
      diff = {1'b0, wd1_ff} + 4'(DaysInWeek) - {1'b0, wd0_ff};
      diff_mod = (diff >= 4'(DaysInWeek)) ? (diff - 4'(DaysInWeek)) : diff;
      case (diff_mod)
         4'd1:    kind_in = KIND_COMMON;
         4'd2:    kind_in = KIND_LEAP;
         default: kind_in = KIND_CHANGEOVER;
      endcase
   end

   // Advance the weekday offset by one whole month
   always_comb begin
      col_sum  = {1'b0, col_ff} + {1'b0, len_mod7(month_len(mcnt_ff, kind_ff))};
      col_step = (col_sum >= 4'(DaysInWeek)) ? 3'(col_sum - 4'(DaysInWeek))
                                              : col_sum[ColWidth-1:0];
   end

   // Day cell sequencing, with the changeover gap in September 1752
   always_comb begin
      skip     = (kind_ff == KIND_CHANGEOVER) && (month_ff == 4'(MonthSeptember));
      last_day = skip ? 5'(ChangeoverLast) : month_len(month_ff, kind_ff);
      bad_in   = (month_ff < 4'(MonthMin)) || (month_ff > 4'(MonthMax)) ||
                 (year_ff < 14'(YearMin)) || (year_ff > 14'(YearMax));
      day_next = (skip && (day_ff == 5'(SkipLastBefore))) ? 5'(SkipResume)
                                                          : (day_ff + 5'd1);
      day_in   = day_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      last_in  = last_ff;
      if (cmd.emit_init) begin
         if (bad_in) begin
            day_in  = '0;
            row_in  = '0;
            col_in  = '0;
            last_in = 1'b1;
         end else begin
            day_in  = 5'd1;
            row_in  = '0;
            last_in = (last_day == 5'd1);
         end
      end else if (cmd.emit_advance) begin
         day_in  = day_next;
         last_in = (day_next == last_day);
         if (col_ff == 3'(DaysInWeek - 1)) begin
            col_in = '0;
            row_in = row_ff + 3'd1;
         end else begin
            col_in = col_ff + 3'd1;
         end
      end else if (cmd.kind_en) begin
         col_in = wd0_ff;
      end else if (cmd.month_step) begin
         col_in = col_step;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         month_ff <= req_tdata[MonthWidth-1:0];
         year_ff  <= req_tdata[MonthWidth +: YearWidth];
      end
      if (cmd.div_en) begin
         base_ff   <= base_in;
         q100_ff   <= p100[Recip100Shift +: 8];
         q400_ff   <= p400[Recip100Shift + 2 +: 6];
         gt1800_ff <= (yr_op > 14'(YearCenturyRule));
         gt1752_ff <= (yr_op > 14'(YearChangeover));
      end
      if (cmd.sum_en) begin
         d_ff <= d_in;
      end
      if (cmd.mul_en) begin
         q7_ff <= p7[Recip7Shift +: 14];
      end
      if (cmd.fix_en) begin
         if (cmd.pass) begin
            wd1_ff <= wd_in;
         end else begin
            wd0_ff <= wd_in;
         end
      end
      if (cmd.kind_en) begin
         kind_ff <= kind_in;
         mcnt_ff <= 4'd1;
      end else if (cmd.month_step) begin
         mcnt_ff <= mcnt_ff + 4'd1;
      end
      if (cmd.emit_init) begin
         bad_ff <= bad_in;
      end
      day_ff  <= day_in;
      row_ff  <= row_in;
      col_ff  <= col_in;
      last_ff <= last_in;
   end

   assign status.bad        = bad_in;
   assign status.month_done = (mcnt_ff == month_ff);
   assign status.beat_last  = last_ff;

   assign rsp_tdata = {5'b00000, col_ff, row_ff, day_ff};
   assign rsp_tuser = bad_ff;
   assign rsp_tlast = last_ff;

endmodule

>>> src/cml_ctrl.sv
// Controller: sequences the weekday passes, the month walk and the beat emission.
module cml_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  cml_pkg::cml_status_type  status,
   output cml_pkg::cml_cmd_type     cmd
);
   import cml_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_CHECK = 9'b000000010,
      ST_DIV   = 9'b000000100,
      ST_SUM   = 9'b000001000,
      ST_MUL   = 9'b000010000,
      ST_FIX   = 9'b000100000,
      ST_KIND  = 9'b001000000,
      ST_MONTH = 9'b010000000,
      ST_EMIT  = 9'b100000000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      pass_ff;
   logic      pass_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_EMIT);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      pass_in  = pass_ff;
      cmd      = '0;
      cmd.pass = pass_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            pass_in = 1'b0;
            if (status.bad) begin
               cmd.emit_init = 1'b1;
               state_in      = ST_EMIT;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_en = 1'b1;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum_en = 1'b1;
            state_in   = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_FIX;
         end
         ST_FIX: begin
            cmd.fix_en = 1'b1;
            if (pass_ff) begin
               pass_in  = 1'b0;
               state_in = ST_KIND;
            end else begin
               pass_in  = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_KIND: begin
            cmd.kind_en = 1'b1;
            state_in    = ST_MONTH;
         end
         ST_MONTH: begin
            if (status.month_done) begin
               cmd.emit_init = 1'b1;
               state_in      = ST_EMIT;
            end else begin
               cmd.month_step = 1'b1;
            end
         end
         ST_EMIT: begin
            if (rsp_tready) begin
               if (status.beat_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.emit_advance = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pass_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
      end
   end

endmodule

>>> tb/calendar_month_layout_tb.sv
// Self-checking testbench for the calendar month layout block: directed and random stream traffic with predicted grids.
module calendar_month_layout_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cml_pkg::*;

   localparam int IdleLimit    = 2000;  // cycles with no beat on either side
   localparam int RandomItems  = 256;
   localparam int DrainCycles  = 60;

   // One printed day cell of the month grid
   typedef struct {
      logic [DayWidth-1:0] day;
      logic [RowWidth-1:0] row;
      logic [ColWidth-1:0] col;
      logic                bad;
      logic                last;
   } day_cell_type;

   // Predicts the day cells of each accepted request and checks the response beats
   class month_grid_board;
      day_cell_type pending_cells[$];
      int unsigned  requests;
      int unsigned  bad_requests;
      int unsigned  cells_checked;
      int unsigned  mismatches;

      function new();
         requests      = 0;
         bad_requests  = 0;
         cells_checked = 0;
         mismatches    = 0;
      endfunction

      // Weekday of January 1: Julian up to the changeover, Gregorian after it
      function int unsigned jan1_weekday(input int unsigned yr);
         int unsigned d;
         d = EpochWeekday + yr + (yr + 3) / 4;
         if (yr > YearCenturyRule) begin
            d -= (yr - CenturyBase) / 100;
            d += (yr - QuadCenturyBase) / 400;
         end
         if (yr > YearChangeover)
            d += GregorianShift;
         return d % DaysInWeek;
      endfunction

      function void push_cell(input int unsigned day, input int unsigned row,
                              input int unsigned col, input bit bad, input bit last);
         day_cell_type c;
         c.day  = day[DayWidth-1:0];
         c.row  = row[RowWidth-1:0];
         c.col  = col[ColWidth-1:0];
         c.bad  = bad;
         c.last = last;
         pending_cells.push_back(c);
      endfunction

      // Lay out the month of one accepted request
      function void note_request(input logic [MonthWidth-1:0] month,
                                 input logic [YearWidth-1:0] year);
         int unsigned m, y, wd, kind, col, row, last_day, i;
         int unsigned days_in[13];
         bit          skip;
         m = 32'(month);
         y = 32'(year);
         requests++;
         if (m < MonthMin || m > MonthMax || y < YearMin || y > YearMax) begin
            bad_requests++;
            push_cell(0, 0, 0, 1'b1, 1'b1);
            return;
         end
         days_in = '{0, 31, 29, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
         wd   = jan1_weekday(y);
         kind = (jan1_weekday(y + 1) + DaysInWeek - wd) % DaysInWeek;
         // Common year shortens February; the changeover year shortens September
         if (kind == 1)
            days_in[MonthFebruary] = 28;
         else if (kind != 2)
            days_in[MonthSeptember] = 19;
         for (i = 1; i < m; i++)
            wd += days_in[i];
         col      = wd % DaysInWeek;
         row      = 0;
         skip     = (days_in[m] == 19);
         last_day = skip ? ChangeoverLast : days_in[m];
         i = 1;
         while (i <= last_day) begin
            // Jump over the dropped days of the changeover month
            if (skip && i == SkipLastBefore + 1)
               i = SkipResume;
            push_cell(i, row, col, 1'b0, i == last_day);
            col++;
            if (col == DaysInWeek) begin
               col = 0;
               row++;
            end
            i++;
         end
      endfunction

      function void check_cell(input day_cell_type got);
         day_cell_type want;
         cells_checked++;
         if (pending_cells.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("MISMATCH: unexpected cell day=%0d row=%0d col=%0d bad=%0d last=%0d",
                        got.day, got.row, got.col, got.bad, got.last);
            return;
         end
         want = pending_cells.pop_front();
         if (got.day !== want.day || got.row !== want.row || got.col !== want.col ||
             got.bad !== want.bad || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("MISMATCH: expected day=%0d row=%0d col=%0d bad=%0d last=%0d, %s",
                        want.day, want.row, want.col, want.bad, want.last,
                        $sformatf("got day=%0d row=%0d col=%0d bad=%0d last=%0d",
                                  got.day, got.row, got.col, got.bad, got.last));
         end
      endfunction

      function int unsigned outstanding();
         return pending_cells.size();
      endfunction
   endclass

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [ReqDataWidth-1:0] req_tdata  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RspDataWidth-1:0] rsp_tdata;
   logic                    rsp_tuser;
   logic                    rsp_tlast;

   month_grid_board board = new();
   bit              req_steady = 1'b0;
   bit              rsp_steady = 1'b0;
   int unsigned     idle_cycles = 0;

   calendar_month_layout dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hold valid across back-to-back beats; drop it only for a real gap
   task automatic send_request(input logic [MonthWidth-1:0] month,
                               input logic [YearWidth-1:0] year);
      int unsigned gap;
      gap = req_steady ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(ReqDataWidth - MonthWidth - YearWidth){1'b0}}, year, month};
      do @(posedge clock); while (!req_tready);
      board.note_request(month, year);
   endtask

   // Draw a request: mostly valid months, with years weighted toward the range edges, 1752 and centuries
   task automatic send_random_request();
      logic [MonthWidth-1:0] month;
      logic [YearWidth-1:0]  year;
      int unsigned           pick;
      month = 4'($urandom_range(MonthMin, MonthMax));
      pick  = $urandom_range(0, 99);
      if (pick < 35)
         year = 14'($urandom_range(YearMin, YearMax));
      else if (pick < 55)
         year = 14'($urandom_range(1740, 1810));
      else if (pick < 63)
         year = 14'($urandom_range(1, 40));
      else if (pick < 70)
         year = 14'($urandom_range(9960, 9999));
      else if (pick < 78)
         year = 14'(100 * $urandom_range(1, 99));
      else if (pick < 85)
         year = 14'(YearChangeover);
      else if (pick < 90) begin
         month = 4'($urandom_range(0, 15));
         year  = 14'($urandom_range(0, 16383));
      end else if (pick < 95) begin
         month = ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(13, 15));
         year  = 14'($urandom_range(YearMin, YearMax));
      end else
         year = ($urandom_range(0, 1) == 0) ? 14'd0 : 14'($urandom_range(10000, 16383));
      send_request(month, year);
   endtask

   // Accept response beats with random stalls and check each one
   initial begin
      int unsigned  stall;
      day_cell_type got;
      do @(posedge clock); while (reset);
      forever begin
         if ($urandom_range(0, 59) == 0)
            rsp_steady = ~rsp_steady;
         stall = rsp_steady ? 0 : $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got.day  = rsp_tdata[DayWidth-1:0];
         got.row  = rsp_tdata[DayWidth +: RowWidth];
         got.col  = rsp_tdata[DayWidth + RowWidth +: ColWidth];
         got.bad  = rsp_tuser;
         got.last = rsp_tlast;
         board.check_cell(got);
      end
   end

   // Watchdog: end the run when neither side moves a beat for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IdleLimit) begin
            $display("watchdog: no beat for %0d cycles, %0d cells outstanding",
                     IdleLimit, board.outstanding());
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // Main sequence: reset, directed corners, random traffic, drain
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Range edges and the first and last valid years
      send_request(4'd1, 14'd1);
      send_request(4'd12, 14'd9999);
      send_request(4'd1, 14'd9999);
      // Changeover year, its skipped September and its neighbors
      send_request(4'd9, 14'd1752);
      send_request(4'd2, 14'd1752);
      send_request(4'd8, 14'd1752);
      send_request(4'd10, 14'd1752);
      send_request(4'd12, 14'd1752);
      send_request(4'd9, 14'd1751);
      send_request(4'd1, 14'd1753);
      // Century and leap rules on February
      send_request(4'd2, 14'd1700);
      send_request(4'd2, 14'd1800);
      send_request(4'd2, 14'd1801);
      send_request(4'd2, 14'd1900);
      send_request(4'd2, 14'd2000);
      send_request(4'd2, 14'd2004);
      send_request(4'd3, 14'd8192);
      // Out-of-range months and years
      send_request(4'd0, 14'd2024);
      send_request(4'd13, 14'd2024);
      send_request(4'd15, 14'd16383);
      send_request(4'd6, 14'd0);
      send_request(4'd7, 14'd10000);
      send_request(4'd0, 14'd0);
      send_request(4'd4, 14'd12345);

      for (int n = 0; n < RandomItems; n++) begin
         if ($urandom_range(0, 29) == 0)
            req_steady = ~req_steady;
         send_random_request();
      end
      req_tvalid <= 1'b0;

      while (board.outstanding() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("covered %0d requests (%0d out of range) across Julian, Gregorian and 1752",
               board.requests, board.bad_requests);
      $display("checked %0d day cells, %0d mismatches", board.cells_checked, board.mismatches);
      if (board.mismatches == 0 && board.outstanding() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

>>> sim.f
src/cml_pkg.sv
src/cml_datapath.sv
src/cml_ctrl.sv
src/calendar_month_layout.sv
tb/calendar_month_layout_tb.sv
